// File: design/nstm_pkg.sv
// Package for the nested scope timing monitor.
// Holds field widths, codes, defaults and the result and aggregate types.
// No dependencies.
package nstm_pkg;

  localparam int unsigned NODE_SLOTS_DEF  = 1024;
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned NAME_SLOTS_DEF  = 256;

  localparam int unsigned TS_W      = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned NAME_W    = 8;
  localparam int unsigned IDX_OUT_W = 10;
  localparam int unsigned REFD_W    = 8;
  localparam int unsigned PADDR_W   = 2;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [PADDR_W-1:0] ADDR_ROOT_NAME = '0;

  localparam logic [REFD_W-1:0] REFUSE_MAX = '1;

  typedef enum logic [1:0] {
    MODE_BEGIN_FRAME = 2'd0,
    MODE_BEGIN_SCOPE = 2'd1,
    MODE_END_SCOPE   = 2'd2,
    MODE_END_FRAME   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_POOL_FULL  = 2'd1,
    STAT_STACK_FULL = 2'd2,
    STAT_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SCOPE,
    ST_END,
    ST_POP,
    ST_RDN,
    ST_NODE,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_OUT_W-1:0] node_index;
    logic [NAME_W-1:0]    scope_name;
    logic [TS_W-1:0]      inclusive_ns;
    logic [TS_W-1:0]      child_ns;
    logic [CNT_W-1:0]     node_calls;
    logic [TS_W-1:0]      agg_total;
    logic [CNT_W-1:0]     agg_count;
    logic [TS_W-1:0]      agg_max;
    logic [TS_W-1:0]      agg_min;
    logic [TS_W-1:0]      frame_total;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [TS_W-1:0]  total;
    logic [CNT_W-1:0] count;
    logic [TS_W-1:0]  max;
    logic [TS_W-1:0]  min;
  } agg_t;

endpackage

// File: design/nstm_ifs.sv
// Valid/ready channel interfaces for the monitor's event and result items.
// Depends on nstm_pkg.
interface nstm_in_if import nstm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [NAME_W-1:0] name_id;
  logic [TS_W-1:0]   timestamp;

  modport source(output valid, mode, name_id, timestamp, input ready);
  modport sink(input valid, mode, name_id, timestamp, output ready);
endinterface

interface nstm_out_if import nstm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [IDX_OUT_W-1:0] node_index;
  logic [NAME_W-1:0]    scope_name;
  logic [TS_W-1:0]      inclusive_ns;
  logic [TS_W-1:0]      child_ns;
  logic [CNT_W-1:0]     node_calls;
  logic [TS_W-1:0]      agg_total;
  logic [CNT_W-1:0]     agg_count;
  logic [TS_W-1:0]      agg_max;
  logic [TS_W-1:0]      agg_min;
  logic [TS_W-1:0]      frame_total;
  logic                 last;

  modport source(output valid, status, node_index, scope_name, inclusive_ns, child_ns,
                 node_calls, agg_total, agg_count, agg_max, agg_min, frame_total, last,
                 input ready);
  modport sink(input valid, status, node_index, scope_name, inclusive_ns, child_ns,
               node_calls, agg_total, agg_count, agg_max, agg_min, frame_total, last,
               output ready);
endinterface

// File: design/nstm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nstm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/nstm_apb.sv
// APB register port holding the root name id.
// Depends on nstm_pkg.
module nstm_apb import nstm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  output logic [NAME_W-1:0]  root_o
);
  logic [NAME_W-1:0] root_q;
  logic [NAME_W-1:0] root_d;

  always_comb begin
    root_d = root_q;
    if (psel_i && penable_i && pwrite_i && (paddr_i == ADDR_ROOT_NAME)) begin
      root_d = pwdata_i[NAME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else begin
      root_q <= root_d;
    end
  end

  assign prdata_o = (paddr_i == ADDR_ROOT_NAME) ? PDATA_W'(root_q) : '0;
  assign root_o   = root_q;
endmodule

// File: design/nested_scope_timing_monitor_top.sv
// Nested scope timing monitor, top level. Depends on nstm_pkg, nstm_ifs, nstm_ram, nstm_apb.
// One item at a time: a new item is taken only in idle; output stalls can hold it longer.
// A begin scope with no open frame opens one first. End scope: pop the top node, read it,
// read parent and aggregate, write both back. End frame closes each open node, no aggregate
// write, then emits the frame total. Reset clears control state and the aggregate valid
// bits; memories are not cleared and need no clearing pass.
module nested_scope_timing_monitor_top import nstm_pkg::*; #(
  parameter int unsigned NODE_SLOTS  = NODE_SLOTS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned NAME_SLOTS  = NAME_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  nstm_in_if.sink            in_i,
  nstm_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  localparam int unsigned IW  = $clog2(NODE_SLOTS);
  localparam int unsigned SW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned NW  = $clog2(NAME_SLOTS);

  typedef struct packed {
    logic              has_par;
    logic [IW-1:0]     par;
    logic [NAME_W-1:0] name;
    logic [TS_W-1:0]   start;
    logic [TS_W-1:0]   child;
  } node_t;

  logic [NAME_W-1:0] root;

  nstm_apb u_apb (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .root_o(root)
  );
  assign pready = 1'b1;

  state_e              state_q, state_d;
  mode_e               mode_q;
  logic [NAME_W-1:0]   nm_q;
  logic [TS_W-1:0]     ts_q;
  logic [IW-1:0]       stack_q [STACK_DEPTH];
  logic [SW-1:0]       fill_q, fill_d;
  logic [IW:0]         nfree_q, nfree_d;
  logic [TS_W-1:0]     fstart_q, fstart_d;
  logic                fopen_q, fopen_d;
  logic [REFD_W-1:0]   refd_q, refd_d;
  logic [NAME_SLOTS-1:0] aggv_q;
  logic                aggv_clr, aggv_set;
  logic [IW-1:0]       cur_q, cur_d;
  logic [TS_W-1:0]     elapsed_q, elapsed_d;
  logic [NAME_W-1:0]   cname_q, cname_d;
  logic                hpar_q, hpar_d;
  logic [IW-1:0]       par_q, par_d;
  logic [TS_W-1:0]     child_q, child_d;
  logic                out_valid_q;
  res_t                res_q, res_d;
  logic                emit, out_free, accept;
  logic                stack_we;
  logic [SIW-1:0]      stack_wi;
  logic [IW-1:0]       stack_wd;
  logic [SW-1:0]       fill_m1;
  logic [IW-1:0]       top_idx;

  logic                node_we, node_re;
  logic [IW-1:0]       node_waddr, node_raddr;
  node_t               node_wdata, node_rd;
  logic                agg_we, agg_re;
  logic [NW-1:0]       agg_waddr, agg_raddr;
  agg_t                agg_wdata, agg_rd, agg_cur, agg_new;
  logic                in_range, refused;

  nstm_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_SLOTS)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(node_rd)
  );

  nstm_ram #(.WIDTH($bits(agg_t)), .DEPTH(NAME_SLOTS)) u_agg_ram (
    .clk_i, .we_i(agg_we), .waddr_i(agg_waddr), .wdata_i(agg_wdata),
    .re_i(agg_re), .raddr_i(agg_raddr), .rdata_o(agg_rd)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign fill_m1  = fill_q - 1'b1;
  assign top_idx  = stack_q[fill_m1[SIW-1:0]];
  assign refused  = (32'(nfree_q) >= NODE_SLOTS) || (32'(fill_q) >= STACK_DEPTH)
                    || (refd_q != '0);
  assign in_range = 32'(cname_q) < NAME_SLOTS;
  assign agg_cur  = aggv_q[NW'(cname_q)] ? agg_rd : '0;

  always_comb begin
    agg_new       = agg_cur;
    agg_new.total = agg_cur.total + elapsed_q;
    agg_new.count = agg_cur.count + 1'b1;
    if (elapsed_q > agg_cur.max) begin
      agg_new.max = elapsed_q;
    end
    if (agg_cur.min == '0 || elapsed_q < agg_cur.min) begin
      agg_new.min = elapsed_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_e'(in_i.mode))
            MODE_BEGIN_FRAME: state_d = ST_FRAME;
            MODE_BEGIN_SCOPE: state_d = fopen_q ? ST_SCOPE : ST_FRAME;
            MODE_END_SCOPE:   state_d = ST_END;
            default:          state_d = ST_POP;
          endcase
        end
      end
      ST_FRAME: begin
        if (mode_q == MODE_BEGIN_SCOPE) begin
          state_d = ST_SCOPE;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCOPE: if (out_free) state_d = ST_IDLE;
      ST_END: begin
        if (refd_q != '0 || fill_q == '0) begin
          if (out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_RDN;
        end
      end
      ST_POP:  state_d = (fill_q != '0) ? ST_RDN : ST_FIN;
      ST_RDN:  state_d = ST_NODE;
      ST_NODE: state_d = ST_UPD;
      ST_UPD: begin
        if (out_free) state_d = (mode_q == MODE_END_SCOPE) ? ST_IDLE : ST_POP;
      end
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fill_d = fill_q; nfree_d = nfree_q; fstart_d = fstart_q; fopen_d = fopen_q;
    refd_d = refd_q; cur_d = cur_q; elapsed_d = elapsed_q; cname_d = cname_q;
    hpar_d = hpar_q; par_d = par_q; child_d = child_q;
    aggv_clr = 1'b0; aggv_set = 1'b0;
    stack_we = 1'b0; stack_wi = '0; stack_wd = '0;
    node_we = 1'b0; node_waddr = '0; node_wdata = '0; node_re = 1'b0; node_raddr = '0;
    agg_we = 1'b0; agg_waddr = '0; agg_wdata = '0; agg_re = 1'b0; agg_raddr = '0;
    emit = 1'b0; res_d = '0;
    case (state_q)
      ST_FRAME: begin
        if (mode_q == MODE_BEGIN_SCOPE || out_free) begin
          node_we    = 1'b1;
          node_waddr = '0;
          node_wdata = '{has_par: 1'b0, par: '0, name: root, start: ts_q, child: '0};
          fstart_d   = ts_q;
          nfree_d    = (IW+1)'(1);
          fill_d     = SW'(1);
          stack_we   = 1'b1;
          refd_d     = '0;
          aggv_clr   = 1'b1;
          fopen_d    = 1'b1;
          if (mode_q == MODE_BEGIN_FRAME) begin
            emit             = 1'b1;
            res_d.scope_name = root;
            res_d.last       = 1'b1;
          end
        end
      end
      ST_SCOPE: begin
        if (out_free) begin
          emit             = 1'b1;
          res_d.scope_name = nm_q;
          res_d.last       = 1'b1;
          if (refused) begin
            res_d.status = (32'(nfree_q) >= NODE_SLOTS) ? STAT_POOL_FULL : STAT_STACK_FULL;
            if (refd_q != REFUSE_MAX) refd_d = refd_q + 1'b1;
          end else begin
            node_we    = 1'b1;
            node_waddr = nfree_q[IW-1:0];
            node_wdata = '{has_par: (fill_q != '0), par: top_idx, name: nm_q,
                           start: ts_q, child: '0};
            stack_we   = 1'b1;
            stack_wi   = fill_q[SIW-1:0];
            stack_wd   = nfree_q[IW-1:0];
            fill_d     = fill_q + 1'b1;
            nfree_d    = nfree_q + 1'b1;
            res_d.node_index = IDX_OUT_W'(nfree_q[IW-1:0]);
          end
        end
      end
      ST_END: begin
        if (refd_q != '0) begin
          if (out_free) begin
            refd_d     = refd_q - 1'b1;
            emit       = 1'b1;
            res_d.last = 1'b1;
          end
        end else if (fill_q == '0) begin
          if (out_free) begin
            emit         = 1'b1;
            res_d.status = STAT_EMPTY;
            res_d.last   = 1'b1;
          end
        end else begin
          fill_d = fill_m1;
          cur_d  = top_idx;
        end
      end
      ST_POP: begin
        if (fill_q != '0) begin
          fill_d = fill_m1;
          cur_d  = top_idx;
        end
      end
      ST_RDN: begin
        node_re    = 1'b1;
        node_raddr = cur_q;
      end
      ST_NODE: begin
        elapsed_d  = (ts_q > node_rd.start) ? ts_q - node_rd.start : '0;
        cname_d    = node_rd.name;
        hpar_d     = node_rd.has_par;
        par_d      = node_rd.par;
        child_d    = node_rd.child;
        node_re    = 1'b1;
        node_raddr = node_rd.par;
        agg_re     = 1'b1;
        agg_raddr  = NW'(node_rd.name);
      end
      ST_UPD: begin
        if (out_free) begin
          if (hpar_q) begin
            node_we          = 1'b1;
            node_waddr       = par_q;
            node_wdata       = node_rd;
            node_wdata.child = node_rd.child + elapsed_q;
          end
          emit               = 1'b1;
          res_d.node_index   = IDX_OUT_W'(cur_q);
          res_d.scope_name   = cname_q;
          res_d.inclusive_ns = elapsed_q;
          res_d.child_ns     = child_q;
          res_d.node_calls   = CNT_W'(1);
          res_d.last         = (mode_q == MODE_END_SCOPE);
          if (in_range) begin
            if (mode_q == MODE_END_SCOPE) begin
              agg_we    = 1'b1;
              agg_waddr = NW'(cname_q);
              agg_wdata = agg_new;
              aggv_set  = 1'b1;
              res_d.agg_total = agg_new.total;
              res_d.agg_count = agg_new.count;
              res_d.agg_max   = agg_new.max;
              res_d.agg_min   = agg_new.min;
            end else begin
              res_d.agg_total = agg_cur.total;
              res_d.agg_count = agg_cur.count;
              res_d.agg_max   = agg_cur.max;
              res_d.agg_min   = agg_cur.min;
            end
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit              = 1'b1;
          res_d.scope_name  = root;
          res_d.frame_total = (ts_q > fstart_q) ? ts_q - fstart_q : '0;
          res_d.last        = 1'b1;
          refd_d            = '0;
          fopen_d           = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      nfree_q     <= '0;
      fstart_q    <= '0;
      fopen_q     <= 1'b0;
      refd_q      <= '0;
      aggv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      nfree_q     <= nfree_d;
      fstart_q    <= fstart_d;
      fopen_q     <= fopen_d;
      refd_q      <= refd_d;
      out_valid_q <= emit || (out_valid_q && !out_o.ready);
      if (aggv_clr) begin
        aggv_q <= '0;
      end else if (aggv_set) begin
        aggv_q[NW'(cname_q)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(in_i.mode);
      nm_q   <= in_i.name_id;
      ts_q   <= in_i.timestamp;
    end
    if (stack_we) begin
      stack_q[stack_wi] <= stack_wd;
    end
    if (emit) begin
      res_q <= res_d;
    end
    cur_q     <= cur_d;
    elapsed_q <= elapsed_d;
    cname_q   <= cname_d;
    hpar_q    <= hpar_d;
    par_q     <= par_d;
    child_q   <= child_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.node_index   = res_q.node_index;
  assign out_o.scope_name   = res_q.scope_name;
  assign out_o.inclusive_ns = res_q.inclusive_ns;
  assign out_o.child_ns     = res_q.child_ns;
  assign out_o.node_calls   = res_q.node_calls;
  assign out_o.agg_total    = res_q.agg_total;
  assign out_o.agg_count    = res_q.agg_count;
  assign out_o.agg_max      = res_q.agg_max;
  assign out_o.agg_min      = res_q.agg_min;
  assign out_o.frame_total  = res_q.frame_total;
  assign out_o.last         = res_q.last;
endmodule

// File: sim/tb.sv
// Testbench for nested_scope_timing_monitor_top: directed and random event items,
// a behavioral predictor of the scope tree and aggregates, and per-field result checks.
// Depends on nstm_pkg, nstm_ifs and the design files.
`timescale 1ns / 100ps
module tb;
  import nstm_pkg::*;

  localparam int unsigned NODES = NODE_SLOTS_DEF;
  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned NAMES = NAME_SLOTS_DEF;
  localparam int unsigned NIL   = NODES;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    mode_e             mode;
    logic [NAME_W-1:0] name_id;
    logic [TS_W-1:0]   timestamp;
  } event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  nstm_in_if  ev_if ();
  nstm_out_if res_if ();

  nested_scope_timing_monitor_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(ev_if.sink), .out_o(res_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  int unsigned        p_parent[NODES];
  int unsigned        p_child[NODES];
  int unsigned        p_sib[NODES];
  logic [NAME_W-1:0]  p_name[NODES];
  logic [TS_W-1:0]    p_start[NODES];
  logic [TS_W-1:0]    p_total[NODES];
  logic [TS_W-1:0]    p_ctime[NODES];
  logic [CNT_W-1:0]   p_count[NODES];
  int unsigned        p_stack[DEPTH];
  int unsigned        p_fill, p_next_free, p_refused;
  logic [TS_W-1:0]    p_frame_start;
  bit                 p_frame_open;
  logic [NAME_W-1:0]  p_root_name;
  agg_t               p_agg[NAMES];

  res_t   expected_results[$];
  event_t pending_events[$];
  int unsigned errors;
  longint unsigned cycles;
  bit done_feeding;
  int unsigned in_gap, out_stall;

  function automatic int unsigned alloc_node(logic [NAME_W-1:0] nm, int unsigned par,
                                             logic [TS_W-1:0] ts);
    int unsigned idx;
    idx = p_next_free++;
    p_name[idx] = nm;
    p_parent[idx] = par;
    p_child[idx] = NIL;
    p_sib[idx] = NIL;
    p_start[idx] = ts;
    p_total[idx] = '0;
    p_ctime[idx] = '0;
    p_count[idx] = '0;
    if (par < NIL) begin
      p_sib[idx] = p_child[par];
      p_child[par] = idx;
    end
    return idx;
  endfunction

  function automatic void open_frame(logic [TS_W-1:0] ts);
    p_frame_start = ts;
    p_next_free = 0;
    p_fill = 0;
    p_refused = 0;
    foreach (p_agg[i]) p_agg[i] = '0;
    p_stack[p_fill++] = alloc_node(p_root_name, NIL, ts);
    p_frame_open = 1'b1;
  endfunction

  function automatic void close_node(int unsigned idx, logic [TS_W-1:0] ts);
    logic [TS_W-1:0] el;
    el = (ts > p_start[idx]) ? ts - p_start[idx] : '0;
    p_total[idx] += el;
    p_count[idx]++;
    if (p_parent[idx] < NIL) p_ctime[p_parent[idx]] += p_total[idx];
  endfunction

  function automatic res_t node_result(int unsigned idx);
    res_t r;
    r = '0;
    r.node_index = idx[IDX_OUT_W-1:0];
    r.scope_name = p_name[idx];
    r.inclusive_ns = p_total[idx];
    r.child_ns = p_ctime[idx];
    r.node_calls = p_count[idx];
    r.agg_total = p_agg[p_name[idx]].total;
    r.agg_count = p_agg[p_name[idx]].count;
    r.agg_max = p_agg[p_name[idx]].max;
    r.agg_min = p_agg[p_name[idx]].min;
    return r;
  endfunction

  function automatic void predict_event(event_t e);
    res_t r;
    int unsigned idx;
    logic [TS_W-1:0] s, ftot;
    r = '0;
    case (e.mode)
      MODE_BEGIN_FRAME: begin
        open_frame(e.timestamp);
        r.scope_name = p_root_name;
      end
      MODE_BEGIN_SCOPE: begin
        if (!p_frame_open) open_frame(e.timestamp);
        r.scope_name = e.name_id;
        if (p_next_free >= NODES || p_fill >= DEPTH || p_refused > 0) begin
          r.status = (p_next_free >= NODES) ? STAT_POOL_FULL : STAT_STACK_FULL;
          if (p_refused < REFUSE_MAX) p_refused++;
        end else begin
          idx = alloc_node(e.name_id, (p_fill > 0) ? p_stack[p_fill-1] : NIL, e.timestamp);
          p_stack[p_fill++] = idx;
          r.node_index = idx[IDX_OUT_W-1:0];
        end
      end
      MODE_END_SCOPE: begin
        if (p_refused > 0) begin
          p_refused--;
        end else if (p_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          idx = p_stack[--p_fill];
          close_node(idx, e.timestamp);
          s = p_total[idx];
          p_agg[p_name[idx]].total += s;
          p_agg[p_name[idx]].count++;
          if (s > p_agg[p_name[idx]].max) p_agg[p_name[idx]].max = s;
          if (p_agg[p_name[idx]].min == 0 || s < p_agg[p_name[idx]].min)
            p_agg[p_name[idx]].min = s;
          r = node_result(idx);
        end
      end
      default: begin
        ftot = (e.timestamp > p_frame_start) ? e.timestamp - p_frame_start : '0;
        while (p_fill > 0) begin
          idx = p_stack[--p_fill];
          close_node(idx, e.timestamp);
          expected_results = {expected_results, node_result(idx)};
        end
        p_refused = 0;
        p_frame_open = 1'b0;
        r.scope_name = p_root_name;
        r.frame_total = ftot;
      end
    endcase
    r.last = 1'b1;
    expected_results = {expected_results, r};
  endfunction

  task automatic report_mismatch(string what, logic [TS_W-1:0] got, logic [TS_W-1:0] want);
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ev_if.valid && ev_if.ready) begin
        predict_event(event_t'({ev_if.mode, ev_if.name_id, ev_if.timestamp}));
        void'(pending_events.pop_front());
        in_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end
      if (ev_if.valid && !ev_if.ready) begin
      end else if (in_gap > 0 && !(ev_if.valid && ev_if.ready)) begin
        in_gap <= in_gap - 1;
        ev_if.valid <= 1'b0;
      end else if (ev_if.valid && ev_if.ready) begin
        ev_if.valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        ev_if.valid <= 1'b1;
        ev_if.mode <= pending_events[0].mode;
        ev_if.name_id <= pending_events[0].name_id;
        ev_if.timestamp <= pending_events[0].timestamp;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result item (t=%0t)", $time);
          errors++;
        end else begin
          w = expected_results.pop_front();
          if (res_if.status !== w.status)
            report_mismatch("status", TS_W'(res_if.status), TS_W'(w.status));
          if (res_if.node_index !== w.node_index)
            report_mismatch("node_index", TS_W'(res_if.node_index), TS_W'(w.node_index));
          if (res_if.scope_name !== w.scope_name)
            report_mismatch("scope_name", TS_W'(res_if.scope_name), TS_W'(w.scope_name));
          if (res_if.inclusive_ns !== w.inclusive_ns)
            report_mismatch("inclusive_ns", res_if.inclusive_ns, w.inclusive_ns);
          if (res_if.child_ns !== w.child_ns)
            report_mismatch("child_ns", res_if.child_ns, w.child_ns);
          if (res_if.node_calls !== w.node_calls)
            report_mismatch("node_calls", TS_W'(res_if.node_calls), TS_W'(w.node_calls));
          if (res_if.agg_total !== w.agg_total)
            report_mismatch("agg_total", res_if.agg_total, w.agg_total);
          if (res_if.agg_count !== w.agg_count)
            report_mismatch("agg_count", TS_W'(res_if.agg_count), TS_W'(w.agg_count));
          if (res_if.agg_max !== w.agg_max) report_mismatch("agg_max", res_if.agg_max, w.agg_max);
          if (res_if.agg_min !== w.agg_min) report_mismatch("agg_min", res_if.agg_min, w.agg_min);
          if (res_if.frame_total !== w.frame_total)
            report_mismatch("frame_total", res_if.frame_total, w.frame_total);
          if (res_if.last !== w.last)
            report_mismatch("last", TS_W'(res_if.last), TS_W'(w.last));
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        res_if.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: out_stall <= $urandom_range(5, 30);
          1, 2: out_stall <= $urandom_range(0, 2);
          default: out_stall <= 0;
        endcase
        res_if.ready <= (cycles[10:9] == 2'b01) ? 1'b1 : ($urandom_range(0, 4) != 0);
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("[nested_scope_timing_monitor_top] ERROR");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    p_root_name = d[NAME_W-1:0];
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || ev_if.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic void queue_event(mode_e m, logic [NAME_W-1:0] n, logic [TS_W-1:0] t);
    event_t e;
    e.mode = m; e.name_id = n; e.timestamp = t;
    pending_events = {pending_events, e};
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [TS_W-1:0] now;
    int unsigned depth, n;
    ev_if.valid = 1'b0; ev_if.mode = MODE_BEGIN_FRAME; ev_if.name_id = '0;
    ev_if.timestamp = '0; res_if.ready = 1'b0;
    errors = 0; cycles = 0; in_gap = 0; out_stall = 0;
    p_fill = 0; p_next_free = 0; p_refused = 0; p_frame_start = '0;
    p_frame_open = 1'b0; p_root_name = '0;
    foreach (p_agg[i]) p_agg[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty ends, implicit frame, extremes, negative elapsed, stack overflow
    queue_event(MODE_END_SCOPE, 8'h00, 64'd5);
    queue_event(MODE_END_FRAME, 8'hFF, 64'd100);
    queue_event(MODE_BEGIN_SCOPE, 8'hFF, 64'd1000);
    queue_event(MODE_BEGIN_SCOPE, 8'h00, 64'd1010);
    queue_event(MODE_END_SCOPE, 8'hAA, 64'd1005);
    queue_event(MODE_END_SCOPE, 8'h55, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_event(MODE_END_SCOPE, 8'h00, 64'd1);
    queue_event(MODE_END_SCOPE, 8'h00, 64'd2);
    queue_event(MODE_BEGIN_FRAME, 8'h12, 64'hFFFF_FFFF_FFFF_FF00);
    queue_event(MODE_END_FRAME, 8'h00, 64'd0);
    drain();
    apb_write(ADDR_ROOT_NAME, 32'hFFFF_FFFF);
    queue_event(MODE_BEGIN_FRAME, 8'h00, 64'd0);
    for (int i = 0; i < 33; i++) queue_event(MODE_BEGIN_SCOPE, i[7:0], 64'd10 + i);
    queue_event(MODE_END_SCOPE, 8'h00, 64'd200);
    queue_event(MODE_END_SCOPE, 8'h00, 64'd210);
    queue_event(MODE_BEGIN_FRAME, 8'h00, 64'd300);
    queue_event(MODE_BEGIN_FRAME, 8'h00, 64'd290);
    queue_event(MODE_END_FRAME, 8'h00, 64'd250);
    drain();

    // random frames of mostly well-formed nesting
    for (int ph = 0; ph < 3; ph++) begin
      apb_write(ADDR_ROOT_NAME, (ph == 2) ? 32'h0 : $urandom);
      n = 0;
      while (n < 20) begin
        now = ($urandom_range(0, 3) == 0) ? rand_ts() : {32'h0, $urandom_range(0, 1000)};
        queue_event($urandom_range(0, 1) ? MODE_BEGIN_FRAME : MODE_BEGIN_SCOPE,
                    NAME_W'($urandom), now);
        depth = 0; n++;
        for (int k = 0; k < 10; k++) begin
          now += $urandom_range(0, 50);
          if ($urandom_range(0, 9) == 0) begin
            queue_event(mode_e'($urandom_range(0, 3)), NAME_W'($urandom), rand_ts());
          end else if (depth == 0 || ($urandom_range(0, 1) && depth < 5)) begin
            queue_event(MODE_BEGIN_SCOPE, NAME_W'($urandom_range(0, 7)), now);
            depth++;
          end else begin
            queue_event(MODE_END_SCOPE, NAME_W'($urandom), now);
            depth--;
          end
          n++;
        end
        queue_event(MODE_END_FRAME, NAME_W'($urandom), now + $urandom_range(0, 20));
        n++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("[nested_scope_timing_monitor_top] OK");
    end else begin
      $display("[nested_scope_timing_monitor_top] ERROR");
    end
    $finish;
  end

endmodule
